### rtl/idcp_pkg.sv
// ----------------------------------------------------------------------------
// Integer decimate and center: shared package
// Sequencer states, register indexes and the scan status bundle.
// ----------------------------------------------------------------------------
package idcp_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_SRC_WIDTH     = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd2;
	localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd3;

	// Field widths of the stream payloads
	localparam int ARGB_W  = 32;
	localparam int RGB_W   = 24;
	localparam int COORD_W = 12;
	localparam int ALPHA_LSB = 24;
	localparam int OUT_TDATA_W = 2 * COORD_W + RGB_W;

	// Frame setup sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_SW,
		ST_DIV_SH,
		ST_DIV_OW,
		ST_DIV_OH,
		ST_OFFSET,
		ST_EMIT
	} seq_state_t;

	// Status from the raster scan counters
	typedef struct packed {
		logic at_origin;
		logic hit;
	} scan_stat_t;

endpackage

### rtl/idcp_div.sv
// ----------------------------------------------------------------------------
// Integer decimate and center: shared divider
// Restoring divider, one quotient bit per cycle, used for every frame setup
// division in turn.
// ----------------------------------------------------------------------------
module idcp_div #(
	parameter int W = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       trial;
	logic [W:0]       diff;

	// One trial subtraction of the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		diff  = trial - {1'b0, den_q};
	end

	// Control: iteration count, busy and a done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	// A new division is never started on top of a running one
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

### rtl/idcp_scan.sv
// ----------------------------------------------------------------------------
// Integer decimate and center: raster scan counters
// Tracks the source position, the phase within each scale step and the
// output position, and flags pixels that land on the output grid.
// ----------------------------------------------------------------------------
module idcp_scan #(
	parameter int IDX_W = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [IDX_W:0]          frame_w,
	input  logic [IDX_W:0]          frame_h,
	input  logic [IDX_W:0]          scale,
	input  logic [IDX_W:0]          out_w,
	input  logic [IDX_W:0]          out_h,
	output logic [IDX_W-1:0]        out_col,
	output logic [IDX_W-1:0]        out_row,
	output idcp_pkg::scan_stat_t    stat
);

	import idcp_pkg::*;

	logic [IDX_W-1:0] src_col_q;
	logic [IDX_W-1:0] src_row_q;
	logic [IDX_W-1:0] col_phase_q;
	logic [IDX_W-1:0] row_phase_q;
	logic [IDX_W-1:0] out_col_q;
	logic [IDX_W-1:0] out_row_q;
	logic [IDX_W:0]   col_nxt;
	logic [IDX_W:0]   row_nxt;
	logic [IDX_W:0]   col_phase_nxt;
	logic [IDX_W:0]   row_phase_nxt;

	// Incremented positions, one bit wider for the end-of-line compares
	always_comb begin
		col_nxt       = {1'b0, src_col_q} + (IDX_W + 1)'(1);
		row_nxt       = {1'b0, src_row_q} + (IDX_W + 1)'(1);
		col_phase_nxt = {1'b0, col_phase_q} + (IDX_W + 1)'(1);
		row_phase_nxt = {1'b0, row_phase_q} + (IDX_W + 1)'(1);
	end

	// Advance the scan once per processed pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q   <= '0;
			src_row_q   <= '0;
			col_phase_q <= '0;
			row_phase_q <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
		end else if (step) begin
			if (col_nxt >= frame_w) begin
				src_col_q   <= '0;
				col_phase_q <= '0;
				out_col_q   <= '0;
				if (row_nxt >= frame_h) begin
					src_row_q   <= '0;
					row_phase_q <= '0;
					out_row_q   <= '0;
				end else begin
					src_row_q <= row_nxt[IDX_W-1:0];
					if (row_phase_nxt >= scale) begin
						row_phase_q <= '0;
						out_row_q   <= out_row_q + 1'b1;
					end else begin
						row_phase_q <= row_phase_nxt[IDX_W-1:0];
					end
				end
			end else begin
				src_col_q <= col_nxt[IDX_W-1:0];
				if (col_phase_nxt >= scale) begin
					col_phase_q <= '0;
					out_col_q   <= out_col_q + 1'b1;
				end else begin
					col_phase_q <= col_phase_nxt[IDX_W-1:0];
				end
			end
		end
	end

	// A pixel sits on the output grid when both phases are zero and it is
	// inside the output area.
	always_comb begin
		stat.at_origin = (src_col_q == '0) && (src_row_q == '0);
		stat.hit       = (col_phase_q == '0) && (row_phase_q == '0) &&
			({1'b0, out_col_q} < out_w) && ({1'b0, out_row_q} < out_h);
	end

	assign out_col = out_col_q;
	assign out_row = out_row_q;

endmodule

### rtl/integer_decimate_center_pixels.sv
// ----------------------------------------------------------------------------
// Integer decimate and center: top level
// Nearest-neighbor integer downscale of an ARGB raster into a centered window.
// ----------------------------------------------------------------------------
// A pixel inside a frame is taken when s_tready is high and its result is
// registered on m_tdata the next cycle; one pixel per cycle sustained outside
// frame setup while the output is free. The first pixel of a frame runs four
// divisions on the shared divider, with s_tready low. Reset (arst_n low,
// asynchronous) sets the sizes and scale to 1 but the output size to 0, and
// the scan to the frame origin; the first pixel after reset starts a frame.
module integer_decimate_center_pixels #(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [12:0] cfg_data,
	// Source pixel stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] argb
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [11:0] dest_x, [23:12] dest_y, [47:24] rgb
);

	import idcp_pkg::*;

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int DIM_W = IDX_W + 1;
	localparam int DIV_W = DIM_W + 1;
	localparam int CFG_W = 13;
	localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int SUM_W = (DIM_W > COORD_W) ? DIM_W : COORD_W;

	seq_state_t         state_q;
	seq_state_t         state_nxt;

	logic [DIM_W-1:0]   cfg_w_q;
	logic [DIM_W-1:0]   cfg_h_q;
	logic [DIM_W-1:0]   win_w_q;
	logic [DIM_W-1:0]   win_h_q;
	logic [CMP_W-1:0]   cfg_ext;
	logic [DIM_W-1:0]   cfg_clamped;

	logic [DIM_W-1:0]   frame_w_q;
	logic [DIM_W-1:0]   frame_h_q;
	logic [DIM_W-1:0]   sw_q;
	logic [DIM_W-1:0]   scale_q;
	logic [DIM_W-1:0]   scale_nxt;
	logic [DIM_W-1:0]   out_w_q;
	logic [DIM_W-1:0]   out_h_q;
	logic [IDX_W-1:0]   offset_x_q;
	logic [IDX_W-1:0]   offset_y_q;
	logic [ARGB_W-1:0]  pix_q;

	logic               div_start;
	logic [DIV_W-1:0]   div_dividend;
	logic [DIV_W-1:0]   div_divisor;
	logic               div_busy;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic [DIM_W-1:0]   quo_dim;

	logic               s_accept;
	logic               out_free;
	logic               step;
	logic [ARGB_W-1:0]  step_pix;
	logic               keep;
	logic [IDX_W-1:0]   out_col;
	logic [IDX_W-1:0]   out_row;
	scan_stat_t         stat;
	logic [SUM_W-1:0]   sum_x;
	logic [SUM_W-1:0]   sum_y;

	logic               m_tvalid_q;
	logic [47:0]        m_tdata_q;

	// Configuration: a zero reads as 1, anything above MAX_DIM as MAX_DIM
	always_comb begin
		cfg_ext = CMP_W'(cfg_data);
		if (cfg_ext == '0) begin
			cfg_clamped = DIM_W'(1);
		end else if (cfg_ext > CMP_W'(MAX_DIM)) begin
			cfg_clamped = DIM_W'(MAX_DIM);
		end else begin
			cfg_clamped = cfg_ext[DIM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= DIM_W'(1);
			cfg_h_q <= DIM_W'(1);
			win_w_q <= DIM_W'(1);
			win_h_q <= DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SRC_WIDTH:     cfg_w_q <= cfg_clamped;
				REG_SRC_HEIGHT:    cfg_h_q <= cfg_clamped;
				REG_WINDOW_WIDTH:  win_w_q <= cfg_clamped;
				REG_WINDOW_HEIGHT: win_h_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	// Handshake terms
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign quo_dim  = div_quo[DIM_W-1:0];
	assign scale_nxt = (quo_dim > sw_q) ? quo_dim : sw_q;

	// Sequencer next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_accept && stat.at_origin) state_nxt = ST_DIV_SW;
			ST_DIV_SW: if (div_done) state_nxt = ST_DIV_SH;
			ST_DIV_SH: if (div_done) state_nxt = ST_DIV_OW;
			ST_DIV_OW: if (div_done) state_nxt = ST_DIV_OH;
			ST_DIV_OH: if (div_done) state_nxt = ST_OFFSET;
			ST_OFFSET: state_nxt = ST_EMIT;
			ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, divider launch and operands, pixel step
	always_comb begin
		s_tready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		step         = 1'b0;
		step_pix     = s_tdata;
		unique case (state_q)
			ST_IDLE: begin
				s_tready     = out_free;
				div_start    = s_accept && stat.at_origin;
				step         = s_accept && !stat.at_origin;
				div_dividend = DIV_W'(cfg_w_q) + DIV_W'(win_w_q) - DIV_W'(1);
				div_divisor  = DIV_W'(win_w_q);
			end
			ST_DIV_SW: begin
				div_start    = div_done;
				div_dividend = DIV_W'(frame_h_q) + DIV_W'(win_h_q) - DIV_W'(1);
				div_divisor  = DIV_W'(win_h_q);
			end
			ST_DIV_SH: begin
				div_start    = div_done;
				div_dividend = DIV_W'(frame_w_q);
				div_divisor  = DIV_W'(scale_nxt);
			end
			ST_DIV_OW: begin
				div_start    = div_done;
				div_dividend = DIV_W'(frame_h_q);
				div_divisor  = DIV_W'(scale_q);
			end
			ST_EMIT: begin
				step     = out_free;
				step_pix = pix_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Frame geometry, filled in one division at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q  <= DIM_W'(1);
			frame_h_q  <= DIM_W'(1);
			sw_q       <= DIM_W'(1);
			scale_q    <= DIM_W'(1);
			out_w_q    <= '0;
			out_h_q    <= '0;
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept && stat.at_origin) begin
						frame_w_q <= cfg_w_q;
						frame_h_q <= cfg_h_q;
					end
				end
				ST_DIV_SW: if (div_done) sw_q <= quo_dim;
				ST_DIV_SH: if (div_done) scale_q <= scale_nxt;
				ST_DIV_OW: if (div_done) out_w_q <= quo_dim;
				ST_DIV_OH: if (div_done) out_h_q <= quo_dim;
				ST_OFFSET: begin
					offset_x_q <= (win_w_q >= out_w_q) ?
						IDX_W'((win_w_q - out_w_q) >> 1) : '0;
					offset_y_q <= (win_h_q >= out_h_q) ?
						IDX_W'((win_h_q - out_h_q) >> 1) : '0;
				end
				default: ;
			endcase
		end
	end

	// Hold the frame's first pixel while the setup runs
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_accept) begin
			pix_q <= s_tdata;
		end
	end

	idcp_div #(
		.W (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	idcp_scan #(
		.IDX_W (IDX_W)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.frame_w (frame_w_q),
		.frame_h (frame_h_q),
		.scale   (scale_q),
		.out_w   (out_w_q),
		.out_h   (out_h_q),
		.out_col (out_col),
		.out_row (out_row),
		.stat    (stat)
	);

	// Keep decision and window coordinates
	always_comb begin
		keep  = step && stat.hit && (step_pix[ARGB_W-1:ALPHA_LSB] != '0);
		sum_x = SUM_W'(offset_x_q) + SUM_W'(out_col);
		sum_y = SUM_W'(offset_y_q) + SUM_W'(out_row);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (keep) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			m_tdata_q <= {step_pix[RGB_W-1:0], sum_y[COORD_W-1:0], sum_x[COORD_W-1:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The scale derived at frame start is never zero
	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		scale_q != '0)
		else $error("scale factor is zero");

	// The decimated frame always fits the window
	a_fits_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (out_w_q <= win_w_q) && (out_h_q <= win_h_q))
		else $error("decimated frame exceeds the window");

	// A frame-start transfer launches the divider and drops ready
	a_setup_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && stat.at_origin) |=> div_busy && !s_tready)
		else $error("frame setup did not start");

	// A result is only produced while the output register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		keep |-> out_free)
		else $error("result overwrote a pending transfer");

endmodule

### tb/integer_decimate_center_pixels_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer decimate and center: testbench
// Streams ARGB rasters through the downscaler under several frame and window
// sizes and random flow control, and checks every output pixel against a
// behavioral model of the decimation and centering kept inside this bench.
// ----------------------------------------------------------------------------
module integer_decimate_center_pixels_tb;

	import idcp_pkg::*;

	localparam int MAX_DIM                = 4096;
	// Long enough for the frame setup to finish, with some margin.
	localparam int SETTLE_CYCLES          = 4 * ($clog2(MAX_DIM) + 3) + 20;
	localparam int WATCHDOG_LIMIT         = 3000;
	localparam int HOLD_OFF_CYCLES        = 300;
	localparam int RANDOM_ITEMS_PER_PHASE = 150;
	localparam int EXTREME_TAIL_ITEMS     = 127;

	// One output pixel as it appears on m_tdata, lowest field last.
	typedef struct packed {
		logic [RGB_W-1:0]   rgb;
		logic [COORD_W-1:0] dest_y;
		logic [COORD_W-1:0] dest_x;
	} placed_pixel_t;

	logic                   clk;
	logic                   arst_n   = 1'b0;
	logic                   cfg_we   = 1'b0;
	logic [1:0]             cfg_addr = REG_SRC_WIDTH;
	logic [12:0]            cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [ARGB_W-1:0]      s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	integer_decimate_center_pixels #(
		.MAX_DIM (MAX_DIM)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Flow control knobs, error tally and the pixels still owed by the block.
	int unsigned     send_idle_pct  = 0;
	int unsigned     recv_stall_pct = 0;
	int unsigned     hold_req       = 0;
	int unsigned     hold_seen      = 0;
	int unsigned     hold_left      = 0;
	int unsigned     quiet_cycles   = 0;
	int unsigned     pixels_sent    = 0;
	int              errors         = 0;
	placed_pixel_t   expected_pixels[$];

	// Register copies as the block sees them after clamping.
	logic [12:0] reg_src_w = 13'd1;
	logic [12:0] reg_src_h = 13'd1;
	logic [12:0] reg_win_w = 13'd1;
	logic [12:0] reg_win_h = 13'd1;

	// Geometry latched at the start of the current frame and the scan position.
	logic [12:0]        latched_w   = 13'd1;
	logic [12:0]        latched_h   = 13'd1;
	logic [12:0]        scale       = 13'd1;
	logic [12:0]        kept_width  = '0;
	logic [12:0]        kept_height = '0;
	logic [COORD_W-1:0] center_x    = '0;
	logic [COORD_W-1:0] center_y    = '0;
	logic [12:0]        scan_col    = '0;
	logic [12:0]        scan_row    = '0;
	logic [12:0]        col_step    = '0;
	logic [12:0]        row_step    = '0;
	logic [12:0]        kept_col    = '0;
	logic [12:0]        kept_row    = '0;

	// Clock with an 8 ns period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Derive scale, output size and centering offsets for a new frame.
	function automatic void latch_frame_geometry();
		int unsigned w, h, ww, wh, sx, sy, s;
		latched_w = reg_src_w;
		latched_h = reg_src_h;
		w = latched_w;
		h = latched_h;
		ww = reg_win_w;
		wh = reg_win_h;
		sx = (w > ww) ? (w + ww - 1) / ww : 1;
		sy = (h > wh) ? (h + wh - 1) / wh : 1;
		s = (sx > sy) ? sx : sy;
		scale = 13'(s);
		kept_width = 13'(w / s);
		kept_height = 13'(h / s);
		center_x = COORD_W'((ww >= w / s) ? (ww - w / s) / 2 : 0);
		center_y = COORD_W'((wh >= h / s) ? (wh - h / s) / 2 : 0);
	endfunction

	// Work out the output of one accepted source pixel and advance the scan.
	function automatic void decimate_pixel(input logic [ARGB_W-1:0] argb);
		placed_pixel_t px;
		if (scan_col == 0 && scan_row == 0)
			latch_frame_geometry();
		if (col_step == 0 && row_step == 0 && kept_col < kept_width &&
				kept_row < kept_height && argb[ARGB_W-1:ALPHA_LSB] != '0) begin
			px.dest_x = center_x + kept_col[COORD_W-1:0];
			px.dest_y = center_y + kept_row[COORD_W-1:0];
			px.rgb = argb[RGB_W-1:0];
			expected_pixels.push_back(px);
		end
		if (scan_col + 1 >= latched_w) begin
			scan_col = '0;
			col_step = '0;
			kept_col = '0;
			if (scan_row + 1 >= latched_h) begin
				scan_row = '0;
				row_step = '0;
				kept_row = '0;
			end else begin
				scan_row++;
				row_step++;
				if (row_step >= scale) begin
					row_step = '0;
					kept_row++;
				end
			end
		end else begin
			scan_col++;
			col_step++;
			if (col_step >= scale) begin
				col_step = '0;
				kept_col++;
			end
		end
	endfunction

	function automatic logic [ARGB_W-1:0] random_argb();
		logic [ARGB_W-1:0] v;
		v = $urandom;
		// A quarter of the pixels are fully transparent.
		if ($urandom_range(3) == 0)
			v[ARGB_W-1:ALPHA_LSB] = '0;
		return v;
	endfunction

	// Every source transfer feeds the model.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			decimate_pixel(s_tdata);
	end

	task automatic report_mismatch(input string field, input int unsigned want,
			input int unsigned got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		errors++;
	endtask

	// Compare every result transfer with the oldest pixel still owed.
	always @(posedge clk) begin : check_results
		placed_pixel_t want;
		placed_pixel_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				if (got.dest_x !== want.dest_x)
					report_mismatch("dest_x", want.dest_x, got.dest_x);
				if (got.dest_y !== want.dest_y)
					report_mismatch("dest_y", want.dest_y, got.dest_y);
				if (got.rgb !== want.rgb)
					report_mismatch("rgb", want.rgb, got.rgb);
			end
		end
	end

	// Result side ready: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_OFF_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// End the run when nothing has been transferred for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one pixel, with random idle cycles ahead of it, until it is taken.
	task automatic send_pixel(input logic [ARGB_W-1:0] argb);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= argb;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pixels_sent++;
	endtask

	// Stop sending, wait for every owed pixel, then let frame setup finish.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Send the rest of a frame left partly sent, so new sizes apply at once.
	task automatic finish_frame();
		int unsigned remaining;
		wait_idle();
		remaining = 0;
		if (scan_col != 0 || scan_row != 0)
			remaining = latched_w * latched_h - (scan_row * latched_w + scan_col);
		repeat (remaining)
			send_pixel(random_argb());
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct <= recv_pct;
	endtask

	// One register write; the enable stays high for a following write.
	task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
		logic [12:0] v;
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		v = value;
		if (v == 0)
			v = 13'd1;
		else if (v > MAX_DIM)
			v = 13'(MAX_DIM);
		case (idx)
			REG_SRC_WIDTH:     reg_src_w = v;
			REG_SRC_HEIGHT:    reg_src_h = v;
			REG_WINDOW_WIDTH:  reg_win_w = v;
			REG_WINDOW_HEIGHT: reg_win_h = v;
			default:           ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [12:0] sw, input logic [12:0] sh,
			input logic [12:0] ww, input logic [12:0] wh);
		wait_idle();
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_WINDOW_WIDTH, ww);
		write_reg(REG_WINDOW_HEIGHT, wh);
		cfg_we <= 1'b0;
	endtask

	// Unscaled 3x2 frame centered in 8x8, with alpha and color extremes.
	task automatic test_basic_frame();
		set_idling(0, 0);
		set_frame(13'd3, 13'd2, 13'd8, 13'd8);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h00FF_FFFF);
		send_pixel(32'h0100_0000);
		send_pixel(32'h8012_3456);
		send_pixel(32'hFF00_0000);
		send_pixel(32'h7FAB_CDEF);
	endtask

	// A 4x3 source in a 2x2 window keeps every second pixel of the first row.
	task automatic test_downscale();
		set_frame(13'd4, 13'd3, 13'd2, 13'd2);
		repeat (12)
			send_pixel({8'hFF, 24'($urandom)});
	endtask

	// New sizes written inside a frame apply only from the next frame.
	task automatic test_mid_frame_write();
		set_frame(13'd3, 13'd1, 13'd4, 13'd4);
		send_pixel(32'hC011_2233);
		send_pixel(32'hC044_5566);
		set_frame(13'd2, 13'd2, 13'd1, 13'd1);
		send_pixel(32'hC077_8899);
		repeat (4)
			send_pixel(32'hFFAA_BBCC);
	endtask

	// Largest sizes and scales, with zero and out-of-range register values clamped.
	task automatic test_extreme_sizes();
		finish_frame();
		// A single pixel centered in the largest window.
		set_frame(13'd1, 13'd1, 13'h1FFF, 13'd4096);
		send_pixel(32'h01FE_DCBA);
		// A tall source in a one-row window shrinks to nothing.
		set_frame(13'd0, 13'd16, 13'd4096, 13'd0);
		repeat (16)
			send_pixel(random_argb());
		// The largest source in a one-column window; the frame is left unfinished.
		set_frame(13'h1FFF, 13'd5000, 13'd1, 13'd4096);
		send_pixel(32'hFF12_3456);
		repeat (EXTREME_TAIL_ITEMS)
			send_pixel(random_argb());
	endtask

	// The result side holds off while the source keeps offering pixels.
	task automatic test_backpressure();
		set_idling(0, 0);
		set_frame(13'd6, 13'd4, 13'd16, 13'd16);
		hold_req <= hold_req + 1;
		repeat (48)
			send_pixel(random_argb());
	endtask

	// Random small frames, back to back, sometimes cut short, in four idling phases.
	task automatic test_random();
		int unsigned phase;
		int unsigned start_count;
		int unsigned pixels;
		logic [12:0] sw, sh, ww, wh;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       set_idling(0, 0);
				1:       set_idling(82, 0);
				2:       set_idling(0, 82);
				default: set_idling(10, 10);
			endcase
			start_count = pixels_sent;
			while (pixels_sent - start_count < RANDOM_ITEMS_PER_PHASE) begin
				sw = 13'(($urandom_range(15) == 0) ? 0 : $urandom_range(1, 16));
				sh = 13'(($urandom_range(15) == 0) ? 0 : $urandom_range(1, 16));
				ww = 13'(($urandom_range(7) == 0) ? $urandom_range(17, 8191) :
					$urandom_range(0, 16));
				wh = 13'(($urandom_range(7) == 0) ? $urandom_range(17, 8191) :
					$urandom_range(0, 16));
				set_frame(sw, sh, ww, wh);
				pixels = $urandom_range(1, 3) * reg_src_w * reg_src_h;
				if ($urandom_range(3) == 0)
					pixels += $urandom_range(1, reg_src_w * reg_src_h);
				// The phase ends on its item count, even inside a frame.
				if (pixels > RANDOM_ITEMS_PER_PHASE - (pixels_sent - start_count))
					pixels = RANDOM_ITEMS_PER_PHASE - (pixels_sent - start_count);
				repeat (pixels)
					send_pixel(random_argb());
			end
		end
	endtask

	initial begin
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		test_basic_frame();
		test_downscale();
		test_mid_frame_write();
		test_backpressure();
		test_random();
		test_extreme_sizes();
		wait_idle();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
rtl/idcp_pkg.sv
rtl/idcp_div.sv
rtl/idcp_scan.sv
rtl/integer_decimate_center_pixels.sv
tb/integer_decimate_center_pixels_tb.sv
